// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/trb_pkg.sv -----
// types and constants of the timestamp reorder buffer
package trb_pkg;

  localparam int TIME_W = 48;
  localparam int TAG_W  = 16;
  localparam int THR_W  = 4;

  localparam logic [THR_W-1:0] THR_RESET = 4'd5;

  typedef logic [TIME_W-1:0] frame_time_t;
  typedef logic [TAG_W-1:0]  frame_tag_t;
  typedef logic [THR_W-1:0]  threshold_t;

  typedef enum logic [1:0] {
    OUT_RELEASED = 2'd0,
    OUT_HELD     = 2'd1,
    OUT_STALE    = 2'd2
  } outcome_t;

  typedef struct packed {
    outcome_t    outcome;
    frame_tag_t  tag;
    frame_time_t time_val;
  } result_t;

endpackage

// ----- rtl/timestamp_reorder_buffer.sv -----
// top level of the timestamp reorder buffer
//
// input channel: frame_time and frame_tag with in_valid / in_stall; a request
// is taken at a clock edge where in_valid is high and in_stall is low
// output channel: outcome, released_tag and released_time with out_valid /
// out_stall; every request gives exactly one result, in request order
// outcome: released oldest frame, held, or dropped as stale
// configuration: cfg_wr_en writes cfg_wr_data into the release threshold; the
// user must write it only while no request is in flight, the block does not enforce this
// path: a taken request waits in the input register, then its result is held in
// the result register; throughput: one request per cycle while out_stall does
// not hold a full result register, set by the combinational compare and shift
// over all SLOTS entries between the input and result registers
// stall: while out_stall holds a full result register, one more request
// waits in the input register and then in_stall rises
// reset: synchronous, clears the fill count, the last released time, both
// valid flags and sets the threshold to 5
`include "assert_macros.svh"

module timestamp_reorder_buffer
  import trb_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TIME_W-1:0]  frame_time,
  input  logic [TAG_W-1:0]   frame_tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         outcome,
  output logic [TAG_W-1:0]   released_tag,
  output logic [TIME_W-1:0]  released_time
);

  localparam int CW = $clog2(SLOTS + 1);

  threshold_t     threshold;
  logic           in_full;
  frame_time_t    in_time;
  frame_tag_t     in_tag;
  logic           out_full;
  result_t        out_res;
  logic           proc;
  logic           in_take;

  frame_time_t    slot_time [SLOTS];
  frame_tag_t     slot_tag  [SLOTS];
  logic [CW-1:0]  fill;
  frame_time_t    last_rel;

  frame_time_t    slot_time_next [SLOTS];
  frame_tag_t     slot_tag_next  [SLOTS];
  logic [CW-1:0]  fill_next;
  frame_time_t    last_rel_next;
  result_t        res_next;

  assign proc     = in_full && (!out_full || !out_stall);
  assign in_stall = in_full && !proc;
  assign in_take  = in_valid && !in_stall;

  trb_insert_release #(
    .SLOTS (SLOTS),
    .CW    (CW)
  ) u_insert (
    .slot_time      (slot_time),
    .slot_tag       (slot_tag),
    .fill           (fill),
    .last_rel       (last_rel),
    .threshold      (threshold),
    .new_time       (in_time),
    .new_tag        (in_tag),
    .slot_time_next (slot_time_next),
    .slot_tag_next  (slot_tag_next),
    .fill_next      (fill_next),
    .last_rel_next  (last_rel_next),
    .result         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
      in_full   <= 1'b0;
      out_full  <= 1'b0;
      fill      <= '0;
      last_rel  <= '0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (in_take) begin
        in_full <= 1'b1;
      end else if (proc) begin
        in_full <= 1'b0;
      end
      if (proc) begin
        out_full <= 1'b1;
        fill     <= fill_next;
        last_rel <= last_rel_next;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_time <= frame_time;
      in_tag  <= frame_tag;
    end
    if (proc) begin
      out_res   <= res_next;
      slot_time <= slot_time_next;
      slot_tag  <= slot_tag_next;
    end
  end

  assign out_valid     = out_full;
  assign outcome       = out_res.outcome;
  assign released_tag  = out_res.tag;
  assign released_time = out_res.time_val;

  `ASSERT_ALWAYS(a_fill_below_cap, fill <= CW'(SLOTS - 1), "fill count reached capacity")
  `ASSERT_IMPLY(a_stall_needs_full, in_stall, in_full && out_full, "stall without pending request")
  `ASSERT_IMPLY(a_idle_fields_zero, out_full && out_res.outcome != OUT_RELEASED,
                out_res.tag == '0 && out_res.time_val == '0, "nonzero fields without release")
  `ASSERT_NEXT(a_stale_keeps_fill, proc && res_next.outcome == OUT_STALE,
               $stable(fill) && $stable(last_rel), "stale request changed buffer state")
  `ASSERT_NEXT(a_release_marks, proc && res_next.outcome == OUT_RELEASED,
               last_rel == out_res.time_val, "last released time not updated")

endmodule

// ----- rtl/trb_insert_release.sv -----
// sorted insertion of one non-stale frame and release of the oldest entry at threshold
module trb_insert_release
  import trb_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int CW    = $clog2(SLOTS + 1)
) (
  input  frame_time_t          slot_time [SLOTS],
  input  frame_tag_t           slot_tag  [SLOTS],
  input  logic [CW-1:0]        fill,
  input  frame_time_t          last_rel,
  input  threshold_t           threshold,
  input  frame_time_t          new_time,
  input  frame_tag_t           new_tag,
  output frame_time_t          slot_time_next [SLOTS],
  output frame_tag_t           slot_tag_next  [SLOTS],
  output logic [CW-1:0]        fill_next,
  output frame_time_t          last_rel_next,
  output result_t              result
);

  localparam int EW = (CW > THR_W) ? CW : THR_W;
  localparam logic [EW-1:0] SLOTS_E = EW'(SLOTS);

  logic              stale;
  logic              release_en;
  logic [EW-1:0]     thr_ext;
  logic [EW-1:0]     thr_eff;
  logic [CW-1:0]     fill_inc;
  logic [SLOTS-1:0]  le;
  frame_time_t       ins_time [SLOTS];
  frame_tag_t        ins_tag  [SLOTS];

  assign stale    = new_time < last_rel;
  assign fill_inc = fill + CW'(1);
  assign thr_ext  = EW'(threshold);

  // zero acts as one, above capacity acts as capacity
  always_comb begin
    priority if (thr_ext == '0) begin
      thr_eff = EW'(1);
    end else if (thr_ext > SLOTS_E) begin
      thr_eff = SLOTS_E;
    end else begin
      thr_eff = thr_ext;
    end
  end

  assign release_en = EW'(fill_inc) >= thr_eff;

  genvar i;
  generate
    for (i = 0; i < SLOTS; i++) begin : g_slot
      assign le[i] = (CW'(i) < fill) && (slot_time[i] <= new_time);
      if (i == 0) begin : g_first
        assign ins_time[i] = le[i] ? slot_time[i] : new_time;
        assign ins_tag[i]  = le[i] ? slot_tag[i]  : new_tag;
      end else begin : g_rest
        assign ins_time[i] = le[i] ? slot_time[i] :
                             le[i-1] ? new_time : slot_time[i-1];
        assign ins_tag[i]  = le[i] ? slot_tag[i] :
                             le[i-1] ? new_tag : slot_tag[i-1];
      end
      if (i == SLOTS - 1) begin : g_last
        assign slot_time_next[i] = stale ? slot_time[i] : ins_time[i];
        assign slot_tag_next[i]  = stale ? slot_tag[i]  : ins_tag[i];
      end else begin : g_shift
        assign slot_time_next[i] = stale ? slot_time[i] :
                                   release_en ? ins_time[i+1] : ins_time[i];
        assign slot_tag_next[i]  = stale ? slot_tag[i] :
                                   release_en ? ins_tag[i+1] : ins_tag[i];
      end
    end
  endgenerate

  always_comb begin
    fill_next     = fill;
    last_rel_next = last_rel;
    result        = '{outcome: OUT_HELD, tag: '0, time_val: '0};
    priority if (stale) begin
      result.outcome = OUT_STALE;
    end else if (release_en) begin
      last_rel_next = ins_time[0];
      result        = '{outcome: OUT_RELEASED, tag: ins_tag[0], time_val: ins_time[0]};
    end else begin
      fill_next = fill_inc;
    end
  end

endmodule

// ----- tb/trb_checker.sv -----
`timescale 1ns / 100ps
// checker for the timestamp reorder buffer: predicts each result and compares it
module trb_checker
  import trb_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  threshold_t  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  frame_time_t frame_time,
  input  frame_tag_t  frame_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  outcome,
  input  frame_tag_t  released_tag,
  input  frame_time_t released_time,
  output int          errors,
  output int          pending
);

  frame_time_t sorted_time [SLOTS];
  frame_tag_t  sorted_tag [SLOTS];
  int          held_count;
  frame_time_t release_mark;
  threshold_t  threshold;
  result_t     expected_results [$];

  function automatic result_t predict_frame(frame_time_t t, frame_tag_t tag);
    result_t r;
    int pos;
    int i;
    int limit;
    r.outcome = OUT_HELD;
    r.tag = '0;
    r.time_val = '0;
    if (t < release_mark) begin
      r.outcome = OUT_STALE;
      return r;
    end
    pos = 0;
    while (pos < held_count && sorted_time[pos] <= t) pos++;
    for (i = held_count; i > pos; i--) begin
      sorted_time[i] = sorted_time[i-1];
      sorted_tag[i] = sorted_tag[i-1];
    end
    sorted_time[pos] = t;
    sorted_tag[pos] = tag;
    held_count++;
    limit = (threshold == 0) ? 1 : ((threshold > SLOTS) ? SLOTS : int'(threshold));
    if (held_count >= limit) begin
      r.outcome = OUT_RELEASED;
      r.tag = sorted_tag[0];
      r.time_val = sorted_time[0];
      release_mark = sorted_time[0];
      for (i = 1; i < held_count; i++) begin
        sorted_time[i-1] = sorted_time[i];
        sorted_tag[i-1] = sorted_tag[i];
      end
      held_count--;
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (errors < 10)
      $display("mismatch %s at %0t: expected %h actual %h", what, $realtime, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      held_count = 0;
      release_mark = '0;
      threshold = THR_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with no request outstanding, outcome", '0, outcome);
        end else begin
          want = expected_results.pop_front();
          if (outcome !== want.outcome)
            note_mismatch("outcome", want.outcome, outcome);
          if (released_tag !== want.tag)
            note_mismatch("released_tag", want.tag, released_tag);
          if (released_time !== want.time_val)
            note_mismatch("released_time", want.time_val, released_time);
        end
      end
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), predict_frame(frame_time, frame_tag));
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/timestamp_reorder_buffer_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the timestamp reorder buffer: stimulus, idling and verdict
module timestamp_reorder_buffer_tb;
  import trb_pkg::*;

  localparam int SLOTS = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 85;
  localparam frame_time_t TIME_MAX = '1;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  threshold_t  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  frame_time_t frame_time;
  frame_tag_t  frame_tag;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  outcome;
  frame_tag_t  released_tag;
  frame_time_t released_time;

  int          errors;
  int          pending;
  int          quiet_cycles;
  bit          calm;
  int          send_gap_pct;
  int          stall_pct;
  frame_time_t now_ms;
  frame_time_t last_time;

  timestamp_reorder_buffer #(.SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_time(frame_time),
    .frame_tag(frame_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .outcome(outcome),
    .released_tag(released_tag),
    .released_time(released_time)
  );

  trb_checker #(.SLOTS(SLOTS)) result_check (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_time(frame_time),
    .frame_tag(frame_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .outcome(outcome),
    .released_tag(released_tag),
    .released_time(released_time),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_frame(frame_time_t t, frame_tag_t tag);
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_time <= t;
    frame_tag <= tag;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_threshold(threshold_t value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic frame_time_t next_frame_time();
    int pick;
    frame_time_t t;
    pick = $urandom_range(0, 99);
    if (pick < 1)
      now_ms += frame_time_t'($urandom_range(1, 1 << 20)) << $urandom_range(0, 24);
    now_ms += frame_time_t'($urandom_range(0, 20));
    if (pick < 8)
      t = now_ms - frame_time_t'($urandom_range(600, 1000));
    else if (pick < 15)
      t = last_time;
    else
      t = now_ms + frame_time_t'($urandom_range(0, 200)) - 100;
    last_time = t;
    return t;
  endfunction

  // receiver side idling
  initial begin
    int window;
    out_stall = 1'b0;
    stall_pct = 0;
    window = 0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 25;
        endcase
        window = $urandom_range(20, 200);
      end
      window--;
      if (calm) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    threshold_t phase_thr [8];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = THR_RESET;
    in_valid = 1'b0;
    frame_time = '0;
    frame_tag = '0;
    calm = 1'b0;
    send_gap_pct = 10;
    quiet_cycles = 0;
    now_ms = 48'd1000;
    last_time = 48'd1000;
    phase_thr = '{4'd1, 4'd8, 4'd4, 4'd0, 4'd15, 4'd2, 4'd6, 4'd3};
    phase_thr[6] = threshold_t'($urandom_range(0, 15));
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // equal times keep arrival order, stale and equal-to-mark frames
    set_threshold(4'd3);
    send_frame(48'd100, 16'h0000);
    send_frame(48'd50, 16'hffff);
    send_frame(48'd100, 16'h0001);
    send_frame(48'd10, 16'h00a5);
    send_frame(48'd50, 16'h0003);
    send_frame(48'd100, 16'h0002);
    send_frame(48'd900, 16'habcd);
    send_frame(48'd0, 16'h5a5a);
    // zero threshold releases on every frame
    set_threshold(4'd0);
    send_frame(48'd200, 16'h0010);
    send_frame(48'd300, 16'h0011);
    // threshold above capacity fills every slot
    set_threshold(4'd15);
    for (int i = 0; i < 8; i++)
      send_frame(48'd400 + 48'(i % 3) * 10, frame_tag_t'(16'h0100 + i));
    // lowered threshold still releases one per frame
    set_threshold(4'd2);
    send_frame(48'd500, 16'h0200);
    send_frame(48'd480, 16'h0201);
    send_frame(48'd520, 16'h0202);

    for (int p = 0; p < 8; p++) begin
      set_threshold(phase_thr[p]);
      case ($urandom_range(0, 2))
        0: send_gap_pct = 0;
        1: send_gap_pct = 10;
        default: send_gap_pct = 30;
      endcase
      if (p == 7) calm = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_frame(next_frame_time(), frame_tag_t'($urandom_range(0, 16'hffff)));
    end

    // largest timestamp, then stale zero and frames equal to the mark
    send_frame(TIME_MAX, 16'hffff);
    send_frame(TIME_MAX, 16'h0000);
    send_frame(TIME_MAX, 16'h1234);
    send_frame(48'd0, 16'h4321);
    send_frame(TIME_MAX, 16'h8001);
    send_frame(TIME_MAX, 16'h7ffe);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/trb_pkg.sv
rtl/trb_insert_release.sv
rtl/timestamp_reorder_buffer.sv
tb/trb_checker.sv
tb/timestamp_reorder_buffer_tb.sv
